FILE: design/pes_pkg.sv
// Package for the percent-encoding stream block.
// Holds the configuration struct, register indexes, constants and the hex digit table.
package pes_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QS_LOW      = 3'd0,
    REG_QS_MID_LOW  = 3'd1,
    REG_QS_MID_HIGH = 3'd2,
    REG_QS_HIGH     = 3'd3,
    REG_SET_ONLY    = 3'd4,
    REG_BUF_SIZE    = 3'd5
  } pes_reg_t;

  localparam logic [63:0] QS_LOW_RESET   = 64'h8000_0804_0000_0000;
  localparam logic [15:0] BUF_SIZE_RESET = 16'd256;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_TERM    = 8'h00;

  typedef struct packed {
    logic [255:0] quote_set;
    logic         set_only;
    logic [15:0]  buffer_size;
  } pes_cfg_t;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_HI   = 2'd1,
    PH_LO   = 2'd2
  } pes_phase_t;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

endpackage

FILE: design/pes_stream_if.sv
// Stream channel interfaces for the percent-encoding block.
// One carries source words, the other carries encoded result words; no dependencies.
interface pes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: design/pes_cfg_regs.sv
// APB-style configuration register file for the percent-encoding block.
// Depends on pes_pkg for register indexes, reset values and the configuration struct.
module pes_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pes_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [pes_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [pes_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output pes_pkg::pes_cfg_t            cfg
);
  import pes_pkg::*;

  logic [63:0]        qs_low_r, qs_mid_low_r, qs_mid_high_r, qs_high_r;
  logic               set_only_r;
  logic [15:0]        buf_size_r;
  logic [CfgIdxW-1:0] idx;
  logic               wr_en;

  assign idx        = cfg_paddr[CfgAddrW-1:CfgAddrW-CfgIdxW];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_low_r      <= QS_LOW_RESET;
      qs_mid_low_r  <= '0;
      qs_mid_high_r <= '0;
      qs_high_r     <= '0;
      set_only_r    <= 1'b0;
      buf_size_r    <= BUF_SIZE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_QS_LOW:      qs_low_r      <= cfg_pwdata;
        REG_QS_MID_LOW:  qs_mid_low_r  <= cfg_pwdata;
        REG_QS_MID_HIGH: qs_mid_high_r <= cfg_pwdata;
        REG_QS_HIGH:     qs_high_r     <= cfg_pwdata;
        REG_SET_ONLY:    set_only_r    <= cfg_pwdata[0];
        REG_BUF_SIZE:    buf_size_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QS_LOW:      cfg_prdata = qs_low_r;
      REG_QS_MID_LOW:  cfg_prdata = qs_mid_low_r;
      REG_QS_MID_HIGH: cfg_prdata = qs_mid_high_r;
      REG_QS_HIGH:     cfg_prdata = qs_high_r;
      REG_SET_ONLY:    cfg_prdata = {63'd0, set_only_r};
      REG_BUF_SIZE:    cfg_prdata = {48'd0, buf_size_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.quote_set   = {qs_high_r, qs_mid_high_r, qs_mid_low_r, qs_low_r};
  assign cfg.set_only    = set_only_r;
  assign cfg.buffer_size = buf_size_r;

endmodule

FILE: design/pes_classify.sv
// Decides whether a source word must be escaped.
// Depends on pes_pkg for the configuration struct and character constants.
module pes_classify (
  input  logic [7:0]        byte_in,
  input  pes_pkg::pes_cfg_t cfg,
  output logic              escape
);
  import pes_pkg::*;

  logic in_set;
  logic unsafe_char;

  assign in_set = cfg.quote_set[byte_in];

  always_comb begin
    unsafe_char = byte_in inside {CHAR_PERCENT, CHAR_QUOTE, [8'd0:8'd32],
                                  [8'd127:8'd160], 8'd255};
  end

  assign escape = in_set || (!cfg.set_only && unsafe_char);

endmodule

FILE: design/pes_encoder.sv
// Input stage, escape sequencer, running count and output register of the encoder.
// Depends on pes_pkg, the stream interfaces and pes_classify.
module pes_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  pes_pkg::pes_cfg_t cfg,
  pes_in_if.sink            in_ch,
  pes_out_if.source         out_ch
);
  import pes_pkg::*;

  logic       stage_valid_r, stage_valid_nxt;
  logic [7:0] stage_byte_r, stage_byte_nxt;
  pes_phase_t phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic       stopped_r, stopped_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       escape, is_term, fits_esc, fits_lit;
  logic       emit, done, step, out_free, accept;
  logic [7:0] emit_byte;

  pes_classify u_classify (
    .byte_in (stage_byte_r),
    .cfg     (cfg),
    .escape  (escape)
  );

  assign is_term  = (stage_byte_r == CHAR_TERM);
  assign fits_esc = ({1'b0, count_r} + 17'd3) < {1'b0, cfg.buffer_size};
  assign fits_lit = ({1'b0, count_r} + 17'd1) < {1'b0, cfg.buffer_size};
  assign out_free = !out_valid_r || out_ch.ready;

  // Output decode for the current phase.
  always_comb begin
    emit      = 1'b0;
    done      = 1'b1;
    emit_byte = stage_byte_r;
    case (phase_r)
      PH_HEAD: begin
        if (is_term) begin
          emit      = 1'b1;
          emit_byte = CHAR_TERM;
        end else if (!stopped_r) begin
          if (escape) begin
            emit      = fits_esc;
            done      = !fits_esc;
            emit_byte = CHAR_PERCENT;
          end else begin
            emit = fits_lit;
          end
        end
      end
      PH_HI: begin
        emit      = 1'b1;
        done      = 1'b0;
        emit_byte = hex_digit(stage_byte_r[7:4]);
      end
      PH_LO: begin
        emit      = 1'b1;
        emit_byte = hex_digit(stage_byte_r[3:0]);
      end
      default: ;
    endcase
  end

  assign step         = stage_valid_r && (out_free || !emit);
  assign in_ch.ready  = !stage_valid_r || (step && done);
  assign accept       = in_ch.valid && in_ch.ready;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_HEAD: phase_nxt = (emit && !done) ? PH_HI : PH_HEAD;
        PH_HI:   phase_nxt = PH_LO;
        PH_LO:   phase_nxt = PH_HEAD;
        default: phase_nxt = PH_HEAD;
      endcase
    end
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_byte_nxt  = stage_byte_r;
    count_nxt       = count_r;
    stopped_nxt     = stopped_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;

    if (step && phase_r == PH_HEAD) begin
      if (is_term) begin
        count_nxt   = '0;
        stopped_nxt = 1'b0;
      end else if (!stopped_r) begin
        if (!emit) begin
          stopped_nxt = 1'b1;
        end else if (escape) begin
          count_nxt = count_r + 16'd3;
        end else begin
          count_nxt = count_r + 16'd1;
        end
      end
    end

    if (step && emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = (phase_r == PH_HEAD) && is_term;
    end

    if (step && done) begin
      stage_valid_nxt = 1'b0;
    end
    if (accept) begin
      stage_valid_nxt = 1'b1;
      stage_byte_nxt  = in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      phase_r       <= PH_HEAD;
      count_r       <= '0;
      stopped_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      phase_r       <= phase_nxt;
      count_r       <= count_nxt;
      stopped_r     <= stopped_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_byte_r <= stage_byte_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

`ifndef NO_ASSERTIONS
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_HEAD && is_term) |=> (count_r == '0 && !stopped_r && out_last_r))
    else $error("Terminator did not clear the string state.");

  a_digit_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEAD) |-> (stage_valid_r && (phase_r == PH_LO || !in_ch.ready)))
    else $error("Hex digit phase without a held source word.");

  a_escape_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_HEAD && emit && !done)
      |=> (phase_r == PH_HI && out_valid_r && out_byte_r == CHAR_PERCENT))
    else $error("Escape did not start with a percent sign.");

  a_hi_to_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HI && step) |=> (phase_r == PH_LO && stage_byte_r == $past(stage_byte_r)))
    else $error("High digit was not followed by the low digit of the same word.");
`endif

endmodule

FILE: design/percent_encode_stream.sv
// Top level of the streaming percent-encoder.
// Depends on pes_pkg, the stream interfaces, pes_cfg_regs and pes_encoder.
//
// Each source word is held in one input register and resolved there: a literal or a
// terminator yields one result word, an escaped byte yields '%' and two uppercase hex
// digits in that order, and a word that no longer fits yields nothing. Throughput is one
// source word per cycle for literals while the output is not stalled; an escaped word
// is held until its three result words are issued. A new word is taken in the cycle the
// held one finishes. Configuration is written over the APB port at byte address 8*i.
module percent_encode_stream (
  input  logic                         clk,
  input  logic                         rst_n,
  pes_in_if.sink                       in_ch,
  pes_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pes_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [pes_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [pes_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import pes_pkg::*;

  pes_cfg_t cfg;

  pes_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pes_encoder u_encoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
